FILE: rtl/core/ria_pkg.sv
// ria_pkg: shared constants, codes and control structs for the rotating id allocator
// used by ria_ctrl, ria_dp, rotating_id_allocator and ria_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ria_pkg;

  // id space and field widths
  localparam int ID_W       = 8;
  localparam int ID_SPACE   = 2 ** ID_W;
  localparam int HI_W       = ID_W + 1;
  localparam int CNT_W      = ID_W + 1;
  localparam int CFG_DATA_W = HI_W;
  localparam int CFG_IDX_W  = 1;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  // default handle width
  localparam int HANDLE_BITS_DEF = 32;

  // used map is scanned one chunk per cycle while the result output is not stalled
  localparam int CHUNK_LOG  = 4;
  localparam int CHUNK_BITS = 2 ** CHUNK_LOG;
  localparam int CIDX_W     = ID_W - CHUNK_LOG;

  // register reset values
  localparam logic [ID_W-1:0] LOW_RESET  = ID_W'(1);
  localparam logic [HI_W-1:0] HIGH_RESET = HI_W'(256);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 1'b0,
    CFG_HIGH_LIMIT = 1'b1
  } cfg_idx_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic range_ok;
    logic found;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ria_ctrl.sv
// ria_ctrl: sequencing state machine of the rotating id allocator
// depends on ria_pkg; drives datapath commands and the handshake of both channels
`timescale 1ns / 1ps
`default_nettype none

module ria_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  input  ria_pkg::dp_stat_t stat_i,
  output ria_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   done;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // item finishes once the search ends or the op needs no search
  assign done = !stat_i.is_alloc || !stat_i.range_ok || stat_i.found || stat_i.last;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_WORK;
        end
      end
      S_WORK: begin
        if (out_free) begin
          if (done) begin
            cmd_o.finish = 1'b1;
            out_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/ria_dp.sv
// ria_dp: datapath of the rotating id allocator: limits, used map, handle store,
// chunked next-fit search, pointer, count and result register; depends on ria_pkg
`timescale 1ns / 1ps
`default_nettype none

module ria_dp #(
  parameter int HANDLE_BITS = ria_pkg::HANDLE_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [ria_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [ria_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire [ria_pkg::OP_W-1:0]          op_i,
  input  wire [ria_pkg::ID_W-1:0]          ident_i,
  input  wire [HANDLE_BITS-1:0]            object_handle_i,
  input  ria_pkg::dp_cmd_t                 cmd_i,
  output ria_pkg::dp_stat_t                stat_o,
  output logic [ria_pkg::STATUS_W-1:0]     status_o,
  output logic [ria_pkg::ID_W-1:0]         granted_id_o,
  output logic [HANDLE_BITS-1:0]           handle_out_o,
  output logic [ria_pkg::CNT_W-1:0]        used_count_o
);

  localparam int ID_W       = ria_pkg::ID_W;
  localparam int HI_W       = ria_pkg::HI_W;
  localparam int CNT_W      = ria_pkg::CNT_W;
  localparam int CHUNK_LOG  = ria_pkg::CHUNK_LOG;
  localparam int CHUNK_BITS = ria_pkg::CHUNK_BITS;
  localparam int CIDX_W     = ria_pkg::CIDX_W;
  localparam int ID_SPACE   = ria_pkg::ID_SPACE;

  // configuration registers
  logic [ID_W-1:0] lo_q;
  logic [HI_W-1:0] hi_q;

  // allocator state
  logic [ID_SPACE-1:0] used_q, used_d;
  logic [ID_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [HANDLE_BITS-1:0] store_mem [ID_SPACE];
  logic [HANDLE_BITS-1:0] rd_q;

  // captured beat
  logic [ria_pkg::OP_W-1:0] op_q;
  logic [ID_W-1:0]          ident_q;
  logic [HANDLE_BITS-1:0]   handle_q;

  // search cursor
  logic [CIDX_W-1:0] chunk_q;
  logic              pass_q;
  logic [ID_W-1:0]   start_q;

  // result register
  logic [ria_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [ID_W-1:0]              res_id_q, res_id_d;
  logic [HANDLE_BITS-1:0]       res_handle_q, res_handle_d;
  logic [CNT_W-1:0]             res_cnt_q;

  logic [ID_W-1:0]       lo_eff;
  logic [HI_W-1:0]       hi_eff;
  logic [HI_W-1:0]       hi_last;
  logic                  range_ok;
  logic [ID_W-1:0]       start_p;
  logic [CHUNK_BITS-1:0] cand;
  logic [CHUNK_LOG-1:0]  hit_off;
  logic                  found;
  logic [ID_W-1:0]       hit_id;
  logic [HI_W-1:0]       hit_next;
  logic                  last0;
  logic                  last1;
  logic                  store_we;

  // effective range: zero low limit acts as one, high limit clipped to the id space
  assign lo_eff   = (lo_q == '0) ? ID_W'(1) : lo_q;
  assign hi_eff   = (hi_q > HI_W'(ID_SPACE)) ? HI_W'(ID_SPACE) : hi_q;
  assign range_ok = (hi_eff > {1'b0, lo_eff});
  assign hi_last  = hi_eff - HI_W'(1);

  // search start: pointer, or low bound when the pointer lies outside the range
  assign start_p = ((ptr_q < lo_eff) || ({1'b0, ptr_q} >= hi_eff)) ? lo_eff : ptr_q;

  // free candidates in the current chunk
  always_comb begin
    logic [ID_W-1:0] id_j;
    logic            in_rng;
    logic            side;
    id_j   = '0;
    in_rng = 1'b0;
    side   = 1'b0;
    cand   = '0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      id_j    = {chunk_q, CHUNK_LOG'(j)};
      in_rng  = (id_j >= lo_eff) && ({1'b0, id_j} < hi_eff);
      side    = pass_q ? (id_j < start_q) : (id_j >= start_q);
      cand[j] = in_rng && side && !used_q[id_j];
    end
  end

  // lowest candidate wins
  always_comb begin
    hit_off = '0;
    for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_off = CHUNK_LOG'(j);
      end
    end
  end

  assign found    = |cand;
  assign hit_id   = {chunk_q, hit_off};
  assign hit_next = {1'b0, hit_id} + HI_W'(1);
  assign last0    = (chunk_q == hi_last[ID_W-1:CHUNK_LOG]);
  assign last1    = pass_q && (chunk_q == start_q[ID_W-1:CHUNK_LOG]);

  assign stat_o.is_alloc = (op_q == ria_pkg::OP_ALLOC);
  assign stat_o.range_ok = range_ok;
  assign stat_o.found    = found;
  assign stat_o.last     = last1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= ria_pkg::LOW_RESET;
      hi_q <= ria_pkg::HIGH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ria_pkg::CFG_LOW_LIMIT:  lo_q <= cfg_data_i[ID_W-1:0];
        ria_pkg::CFG_HIGH_LIMIT: hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      ident_q  <= ident_i;
      handle_q <= object_handle_i;
    end
  end

  // search cursor: start chunk, then wrap to the low bound for the second pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      chunk_q <= start_p[ID_W-1:CHUNK_LOG];
      pass_q  <= 1'b0;
      start_q <= start_p;
    end else if (cmd_i.step) begin
      if (!pass_q && last0) begin
        pass_q  <= 1'b1;
        chunk_q <= lo_eff[ID_W-1:CHUNK_LOG];
      end else begin
        chunk_q <= chunk_q + CIDX_W'(1);
      end
    end
  end

  // item completion: map, pointer, count and result
  always_comb begin
    used_d       = used_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    store_we     = 1'b0;
    res_status_d = ria_pkg::ST_OK;
    res_id_d     = '0;
    res_handle_d = '0;
    case (op_q)
      ria_pkg::OP_ALLOC: begin
        if (found) begin
          used_d[hit_id] = 1'b1;
          store_we       = 1'b1;
          cnt_d          = cnt_q + CNT_W'(1);
          ptr_d          = (hit_next >= hi_eff) ? lo_eff : hit_next[ID_W-1:0];
          res_id_d       = hit_id;
        end else begin
          res_status_d = ria_pkg::ST_FULL;
        end
      end
      ria_pkg::OP_FREE: begin
        if (used_q[ident_q]) begin
          used_d[ident_q] = 1'b0;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end else begin
          res_status_d = ria_pkg::ST_NOT_ALLOC;
        end
      end
      ria_pkg::OP_LOOKUP: begin
        if (used_q[ident_q]) begin
          res_handle_d = rd_q;
        end else begin
          res_status_d = ria_pkg::ST_NOT_ALLOC;
        end
      end
      default: ;
    endcase
  end

  // allocator state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      ptr_q  <= ria_pkg::LOW_RESET;
      cnt_q  <= '0;
    end else if (cmd_i.finish) begin
      used_q <= used_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // handle store write
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && store_we) begin
      store_mem[hit_id] <= handle_q;
    end
  end

  // handle store read, addressed by the incoming beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= store_mem[ident_i];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_handle_q <= res_handle_d;
      res_cnt_q    <= cnt_d;
    end
  end

  assign status_o     = res_status_q;
  assign granted_id_o = res_id_q;
  assign handle_out_o = res_handle_q;
  assign used_count_o = res_cnt_q;

endmodule

`default_nettype wire

FILE: rtl/core/rotating_id_allocator.sv
// sequence: the input beat is captured, then free, lookup, unknown op and empty-range
// allocate register their result; allocate first scans the used map chunk by chunk
// until a free id is found or the last chunk is reached; an output stall holds the item
// flow: one item at a time, the next beat is taken once the result is registered
// reset: used map and count clear, pointer and limits to defaults at once, no
// clearing pass; handle store is not reset
`timescale 1ns / 1ps
`default_nettype none

module rotating_id_allocator #(
  parameter int HANDLE_BITS = ria_pkg::HANDLE_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [ria_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [ria_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [ria_pkg::OP_W-1:0]       op_i,
  input  wire [ria_pkg::ID_W-1:0]       ident_i,
  input  wire [HANDLE_BITS-1:0]         object_handle_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [ria_pkg::STATUS_W-1:0]  status_o,
  output logic [ria_pkg::ID_W-1:0]      granted_id_o,
  output logic [HANDLE_BITS-1:0]        handle_out_o,
  output logic [ria_pkg::CNT_W-1:0]     used_count_o
);

  ria_pkg::dp_cmd_t  cmd;
  ria_pkg::dp_stat_t stat;

  // sequencing
  ria_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage and search
  ria_dp #(
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .ident_i         (ident_i),
    .object_handle_i (object_handle_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status_o),
    .granted_id_o    (granted_id_o),
    .handle_out_o    (handle_out_o),
    .used_count_o    (used_count_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ria_checker.sv
// ria_checker: port-level assertions for the rotating id allocator, bound to the top
// depends on ria_pkg and rotating_id_allocator
`timescale 1ns / 1ps
`default_nettype none

module ria_checker #(
  parameter int HANDLE_BITS = ria_pkg::HANDLE_BITS_DEF
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_stall_o,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [ria_pkg::STATUS_W-1:0]  status_o,
  input wire [ria_pkg::ID_W-1:0]      granted_id_o,
  input wire [HANDLE_BITS-1:0]        handle_out_o,
  input wire [ria_pkg::CNT_W-1:0]     used_count_o
);

  // one item in flight: an accepted beat blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input beat taken while an item is in flight");

  // a granted id only comes with ok status and no handle
  a_grant_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (granted_id_o != '0)) |->
      ((status_o == ria_pkg::ST_OK) && (handle_out_o == '0)))
    else $error("granted id with bad status or handle");

  // status is a known code and the count stays below the id space, as id 0 is never allocated
  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (((status_o == ria_pkg::ST_OK) || (status_o == ria_pkg::ST_FULL) ||
        (status_o == ria_pkg::ST_NOT_ALLOC)) &&
       (used_count_o < ria_pkg::CNT_W'(ria_pkg::ID_SPACE))))
    else $error("bad status code or count out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(granted_id_o) &&
       $stable(handle_out_o) && $stable(used_count_o)))
    else $error("stalled result beat changed");

endmodule

bind rotating_id_allocator ria_checker #(
  .HANDLE_BITS (HANDLE_BITS)
) u_ria_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .granted_id_o (granted_id_o),
  .handle_out_o (handle_out_o),
  .used_count_o (used_count_o)
);

`default_nettype wire
